// ----- sv/plcl_pkg.sv -----
// plcl_pkg: types, constants and state codes of the curve lookup block
// no dependencies; used by the top module, the checker and the testbench
`default_nettype none

package plcl_pkg;

  localparam int TableDepthDef = 256;
  localparam int FracBitsDef   = 32;
  localparam int SearchSteps   = 10;
  localparam int CountWidth    = 9;
  localparam int PointCountRst = 2;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic [7:0]         point_index;
    logic signed [63:0] point_x;
    logic signed [63:0] point_y;
    logic signed [63:0] speed;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] curve_value;
    logic               zero_span;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK0,
    ST_SRCH,
    ST_SWAIT,
    ST_RDA,
    ST_RDB,
    ST_CALC,
    ST_PREP,
    ST_DIV,
    ST_MUL
  } state_e;

endpackage

`default_nettype wire

// ----- sv/piecewise_linear_curve_lookup.sv -----
// piecewise_linear_curve_lookup: point table in ram, binary search,
// iterative divider and partial-product multiplier
// depends on plcl_pkg and plcl_ram
`default_nettype none

// usage
//   input channel: an item is taken at a clock edge with start high and busy
//   low. a write item (func 0) stores point (point_x, point_y) at point_index
//   in the same edge and gives no result; busy stays low, so write items can
//   follow each other every cycle. an index at or beyond the table depth is
//   dropped.
//   an evaluate item (func 1) raises busy until its result is out. the table
//   entries it touches must have been written.
//   result channel: result_valid_o is high for exactly one cycle with
//   result_o; the receiver cannot hold it off, and busy is already low in
//   that cycle so the next item can be taken.
//   config: cfg_we_i writes point_count; the count in use is clamped to
//   2..TABLE_DEPTH. write it only while busy is low.
//   evaluate path: a binary search of up to 10 reads of the point ram (9
//   with 256 points), then the two-bit-per-cycle divider and the
//   partial-product multiplier; its time is set by the single read port of
//   the point ram during the search and by the divider. a speed below the
//   first x skips the search and answers with the first point's y.
//   reset: control state clears; the table is undefined until written.
module piecewise_linear_curve_lookup #(
  parameter int TABLE_DEPTH = plcl_pkg::TableDepthDef,
  parameter int FRAC_BITS   = plcl_pkg::FracBitsDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire plcl_pkg::in_item_t                   item_i,
  output logic                                      result_valid_o,
  output plcl_pkg::out_item_t                       result_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [plcl_pkg::CountWidth-1:0]      cfg_wdata_i
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int NB    = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (NB > plcl_pkg::CountWidth) ? NB : plcl_pkg::CountWidth;
  localparam int IW    = (AW > 8) ? AW : 8;
  localparam int DW    = ((64 + FRAC_BITS) % 2 == 0) ? (64 + FRAC_BITS) : (65 + FRAC_BITS);
  localparam int DSTEP = DW / 2;
  localparam int DCW   = $clog2(DSTEP + 1);
  localparam int SCW   = $clog2(plcl_pkg::SearchSteps + 1);

  plcl_pkg::state_e state_q, state_d;

  logic [plcl_pkg::CountWidth-1:0] cnt_q;
  logic [CW-1:0]        n_q;
  logic signed [CW:0]   l_q, r_q, best_q;
  logic [SCW-1:0]       iter_q;
  logic [AW-1:0]        mid_q, idx_q;
  logic signed [63:0]   spd_q, x0_q, y0_q, num_q, den_q, dy_q;
  logic                 neg_q;
  logic [63:0]          ud_q, rem_q, quo_q;
  logic [DW-1:0]        dvd_q;
  logic [DCW-1:0]       dcnt_q;
  logic [2:0]           mstep_q;
  logic signed [65:0]   pp_q;
  logic [1:0]           ppsel_q;
  logic signed [127:0]  acc_q;
  logic                 valid_q;
  plcl_pkg::out_item_t  res_q;

  // table ram, x in the upper half
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [127:0]     rdata;
  logic [IW-1:0]    pidx;
  logic signed [63:0] rx, ry;

  assign pidx  = IW'(item_i.point_index);
  assign waddr = pidx[AW-1:0];
  assign we    = start && !busy && (item_i.func == plcl_pkg::FUNC_WRITE)
                 && (int'(pidx) < TABLE_DEPTH);
  assign rx    = $signed(rdata[127:64]);
  assign ry    = $signed(rdata[63:0]);

  plcl_ram #(.Width(128), .Depth(TABLE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i({item_i.point_x, item_i.point_y}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // search helpers
  logic signed [CW:0] mid_full, idx_t, nm2;
  logic               srch_go;
  assign mid_full = (l_q + r_q) >>> 1;
  assign srch_go  = (l_q <= r_q) && (int'(iter_q) < plcl_pkg::SearchSteps);
  assign nm2      = $signed({1'b0, n_q}) - (CW+1)'(2);

  always_comb begin
    idx_t = best_q - (CW+1)'(1);
    if (idx_t > nm2) idx_t = nm2;
    if (idx_t < 0)   idx_t = '0;
  end

  // count in use, clamped
  logic [CW-1:0] n_use;
  always_comb begin
    if (int'(cnt_q) < 2) n_use = CW'(2);
    else if (int'(cnt_q) > TABLE_DEPTH) n_use = CW'(TABLE_DEPTH);
    else n_use = CW'(cnt_q);
  end

  // two restoring divide steps per cycle
  logic [63:0] rem_a, rem_b;
  logic [64:0] tr_a, tr_b;
  logic        qa, qb;
  always_comb begin
    tr_a  = {rem_q, dvd_q[DW-1]};
    qa    = tr_a >= {1'b0, ud_q};
    rem_a = qa ? 64'(tr_a - {1'b0, ud_q}) : tr_a[63:0];
    tr_b  = {rem_a, dvd_q[DW-2]};
    qb    = tr_b >= {1'b0, ud_q};
    rem_b = qb ? 64'(tr_b - {1'b0, ud_q}) : tr_b[63:0];
  end

  // one 33x33 partial product per cycle
  logic signed [32:0] ma, mb;
  logic signed [63:0] fr;
  assign fr = neg_q ? -$signed(quo_q) : $signed(quo_q);
  always_comb begin
    case (mstep_q)
      3'd0: begin ma = {1'b0, dy_q[31:0]};     mb = {1'b0, fr[31:0]}; end
      3'd1: begin ma = {1'b0, dy_q[31:0]};     mb = {fr[63], fr[63:32]}; end
      3'd2: begin ma = {dy_q[63], dy_q[63:32]}; mb = {1'b0, fr[31:0]}; end
      default: begin ma = {dy_q[63], dy_q[63:32]}; mb = {fr[63], fr[63:32]}; end
    endcase
  end

  logic signed [127:0] pp_ext;
  always_comb begin
    pp_ext = 128'(pp_q);
    case (ppsel_q)
      2'd0:    pp_ext = pp_ext;
      2'd3:    pp_ext = pp_ext <<< 64;
      default: pp_ext = pp_ext <<< 32;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plcl_pkg::ST_IDLE:
        if (start && (item_i.func == plcl_pkg::FUNC_EVAL)) state_d = plcl_pkg::ST_CHK0;
      plcl_pkg::ST_CHK0:
        state_d = (spd_q < rx) ? plcl_pkg::ST_IDLE : plcl_pkg::ST_SRCH;
      plcl_pkg::ST_SRCH:
        state_d = srch_go ? plcl_pkg::ST_SWAIT : plcl_pkg::ST_RDA;
      plcl_pkg::ST_SWAIT: state_d = plcl_pkg::ST_SRCH;
      plcl_pkg::ST_RDA:   state_d = plcl_pkg::ST_RDB;
      plcl_pkg::ST_RDB:   state_d = plcl_pkg::ST_CALC;
      plcl_pkg::ST_CALC:
        state_d = (rx == x0_q) ? plcl_pkg::ST_IDLE : plcl_pkg::ST_PREP;
      plcl_pkg::ST_PREP:  state_d = plcl_pkg::ST_DIV;
      plcl_pkg::ST_DIV:
        if (dcnt_q == DCW'(1)) state_d = plcl_pkg::ST_MUL;
      plcl_pkg::ST_MUL:
        if (mstep_q == 3'd4) state_d = plcl_pkg::ST_IDLE;
      default: state_d = plcl_pkg::ST_IDLE;
    endcase
  end

  // outputs and ram read address
  always_comb begin
    busy  = 1'b1;
    raddr = '0;
    case (state_q)
      plcl_pkg::ST_IDLE: busy  = 1'b0;
      plcl_pkg::ST_SRCH: raddr = mid_full[AW-1:0];
      plcl_pkg::ST_RDA:  raddr = idx_q;
      plcl_pkg::ST_RDB:  raddr = AW'(idx_q + AW'(1));
      default:           raddr = '0;
    endcase
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plcl_pkg::ST_IDLE;
      cnt_q   <= plcl_pkg::CountWidth'(plcl_pkg::PointCountRst);
      valid_q <= 1'b0;
      dcnt_q  <= '0;
      mstep_q <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      case (state_q)
        plcl_pkg::ST_CHK0:  iter_q <= '0;
        plcl_pkg::ST_SWAIT: iter_q <= SCW'(iter_q + SCW'(1));
        plcl_pkg::ST_PREP:  dcnt_q <= DCW'(DSTEP);
        plcl_pkg::ST_DIV: begin
          dcnt_q  <= DCW'(dcnt_q - DCW'(1));
          mstep_q <= '0;
        end
        plcl_pkg::ST_MUL:   mstep_q <= 3'(mstep_q + 3'd1);
        default: ;
      endcase
      valid_q <= (state_q == plcl_pkg::ST_CHK0 && spd_q < rx) ||
                 (state_q == plcl_pkg::ST_CALC && rx == x0_q) ||
                 (state_q == plcl_pkg::ST_MUL && mstep_q == 3'd4);
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      plcl_pkg::ST_IDLE: begin
        spd_q <= item_i.speed;
        n_q   <= n_use;
      end
      plcl_pkg::ST_CHK0: begin
        res_q.curve_value <= ry;
        res_q.zero_span   <= 1'b0;
        l_q    <= '0;
        r_q    <= $signed({1'b0, n_q}) - (CW+1)'(1);
        best_q <= $signed({1'b0, n_q}) - (CW+1)'(1);
      end
      plcl_pkg::ST_SRCH: begin
        mid_q <= mid_full[AW-1:0];
        idx_q <= idx_t[AW-1:0];
      end
      plcl_pkg::ST_SWAIT: begin
        if (rx < spd_q) begin
          l_q <= $signed({1'b0, (CW)'(mid_q)}) + (CW+1)'(1);
        end else begin
          best_q <= $signed({1'b0, (CW)'(mid_q)});
          r_q    <= $signed({1'b0, (CW)'(mid_q)}) - (CW+1)'(1);
        end
      end
      plcl_pkg::ST_RDB: begin
        x0_q <= rx;
        y0_q <= ry;
      end
      plcl_pkg::ST_CALC: begin
        res_q.curve_value <= y0_q;
        res_q.zero_span   <= 1'b1;
        den_q <= rx - x0_q;
        num_q <= spd_q - x0_q;
        dy_q  <= ry - y0_q;
      end
      plcl_pkg::ST_PREP: begin
        neg_q <= num_q[63] ^ den_q[63];
        ud_q  <= den_q[63] ? 64'(-den_q) : 64'(den_q);
        dvd_q <= DW'({(num_q[63] ? 64'(-num_q) : 64'(num_q)), {FRAC_BITS{1'b0}}});
        rem_q <= '0;
        quo_q <= '0;
      end
      plcl_pkg::ST_DIV: begin
        rem_q <= rem_b;
        quo_q <= {quo_q[61:0], qa, qb};
        dvd_q <= dvd_q << 2;
        acc_q <= '0;
      end
      plcl_pkg::ST_MUL: begin
        pp_q    <= ma * mb;
        ppsel_q <= mstep_q[1:0];
        if (mstep_q != 3'd0) acc_q <= acc_q + pp_ext;
        if (mstep_q == 3'd4) begin
          res_q.curve_value <= y0_q + $signed(acc_q[FRAC_BITS+63:FRAC_BITS]
                               + pp_ext[FRAC_BITS+63:FRAC_BITS]
                               + 64'((acc_q[FRAC_BITS-1:0] + pp_ext[FRAC_BITS-1:0])
                                     >> FRAC_BITS));
          res_q.zero_span   <= 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/plcl_ram.sv -----
// plcl_ram: generic ram, one write port and one read port, registered read
// no dependencies
`default_nettype none

module plcl_ram #(
  parameter int Width = 128,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/plcl_checker.sv -----
// plcl_checker: port-level checks of the curve lookup block, bound to the top
// depends on plcl_pkg and piecewise_linear_curve_lookup
`default_nettype none

module plcl_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic func_i,
  input wire logic result_valid_o
);

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

  // an evaluate item makes the block busy
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == plcl_pkg::FUNC_EVAL) |=> busy)
    else $error("evaluate item did not raise busy");

  // a write item gives no result and leaves the block free
  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == plcl_pkg::FUNC_WRITE) |=> (!busy && !result_valid_o))
    else $error("write item caused work");

  // a result only follows busy work and frees the block
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) && !busy)) else $error("result without work");

endmodule

bind piecewise_linear_curve_lookup plcl_checker u_plcl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .func_i        (item_i.func),
  .result_valid_o(result_valid_o)
);

`default_nettype wire

// ----- tb/sv/piecewise_linear_curve_lookup_tb.sv -----
// piecewise_linear_curve_lookup_tb: self-checking testbench of the curve lookup block
// depends on plcl_pkg and the piecewise_linear_curve_lookup rtl
`timescale 1ns / 1ps

module piecewise_linear_curve_lookup_tb;
  import plcl_pkg::*;

  localparam int Depth       = TableDepthDef;
  localparam int FracBits    = FracBitsDef;
  localparam int DrainCycles = 120;   // quiet margin after the last result
  localparam int StallLimit  = 5000;  // cycles with no handshake at all

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              item_i = '0;
  logic                  result_valid_o;
  out_item_t             result_o;
  logic                  cfg_we_i = 1'b0;
  logic [CountWidth-1:0] cfg_wdata_i = '0;

  piecewise_linear_curve_lookup dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the point table and of the count register
  logic signed [63:0]    curve_x [Depth];
  logic signed [63:0]    curve_y [Depth];
  logic [CountWidth-1:0] point_count_q = CountWidth'(PointCountRst);

  out_item_t expected_curve_q[$];
  int        errors = 0;
  int        items_sent = 0;
  int        evals_checked = 0;
  int        idle_pct = 0;

  // count clamped to the legal range
  function automatic int points_in_use();
    int n;
    n = int'(point_count_q);
    if (n < 2) n = 2;
    if (n > Depth) n = Depth;
    return n;
  endfunction

  // (num << FracBits) / den, signed, truncated toward zero, low 64 bits
  function automatic logic [63:0] frac_divide(logic [63:0] num, logic [63:0] den);
    logic         neg;
    logic [63:0]  un, ud;
    logic [127:0] q;
    neg = num[63] ^ den[63];
    un  = num[63] ? -num : num;
    ud  = den[63] ? -den : den;
    q   = ({64'd0, un} << FracBits) / {64'd0, ud};
    return neg ? -q[63:0] : q[63:0];
  endfunction

  // (a * b) >>> FracBits of the full signed product, low 64 bits
  function automatic logic [63:0] frac_multiply(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p  = wa * wb;
    p  = p >>> FracBits;
    return p[63:0];
  endfunction

  // applies one item to the shadow table and returns the curve value it causes
  function automatic bit predict_curve(in_item_t it, output out_item_t res);
    int n, lo, hi, best, steps, seg, mid;
    logic signed [63:0] spd, x0, x1, y0, y1, den;
    res = '0;
    if (func_e'(it.func) == FUNC_WRITE) begin
      curve_x[it.point_index] = it.point_x;
      curve_y[it.point_index] = it.point_y;
      return 1'b0;
    end
    n   = points_in_use();
    spd = it.speed;
    if (spd < curve_x[0]) begin
      res.curve_value = curve_y[0];
      return 1'b1;
    end
    lo = 0; hi = n - 1; best = hi; steps = 0;
    while (lo <= hi && steps < SearchSteps) begin
      mid = (lo + hi) / 2;
      if (curve_x[mid] < spd) begin
        lo = mid + 1;
      end else begin
        best = mid;
        hi = mid - 1;
      end
      steps++;
    end
    seg = best - 1;
    if (seg > n - 2) seg = n - 2;
    if (seg < 0) seg = 0;   // speed equal to the first x
    x0 = curve_x[seg]; x1 = curve_x[seg+1];
    y0 = curve_y[seg]; y1 = curve_y[seg+1];
    den = x1 - x0;
    if (den == 0) begin
      res.curve_value = y0;
      res.zero_span   = 1'b1;
      return 1'b1;
    end
    res.curve_value = y0 + frac_multiply(y1 - y0, frac_divide(spd - x0, den));
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker: the receiver cannot stall, every strobe is one result
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_curve_q.size() == 0) begin
        report_mismatch("unexpected result", result_o.curve_value, '0);
      end else begin
        want = expected_curve_q.pop_front();
        evals_checked++;
        if (result_o.curve_value !== want.curve_value)
          report_mismatch("curve_value", result_o.curve_value, want.curve_value);
        if (result_o.zero_span !== want.zero_span)
          report_mismatch("zero_span", 64'(result_o.zero_span), 64'(want.zero_span));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL piecewise_linear_curve_lookup");
      $finish;
    end
  end

  // drives one item, with a random sender gap first, and waits until it is taken
  task automatic send_item(in_item_t it);
    out_item_t res;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (predict_curve(it, res)) expected_curve_q.push_back(res);
  endtask

  task automatic write_point(int idx, logic [63:0] x, logic [63:0] y);
    in_item_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.point_index = idx[7:0];
    it.point_x = x;
    it.point_y = y;
    it.speed = rand64();   // don't care on a write
    send_item(it);
  endtask

  task automatic eval_at(logic [63:0] spd);
    in_item_t it;
    it = '0;
    it.func = FUNC_EVAL;
    it.point_index = 8'($urandom());
    it.point_x = rand64();
    it.point_y = rand64();
    it.speed = spd;
    send_item(it);
  endtask

  // sender stops until every result is in, plus a quiet margin
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_curve_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_point_count(logic [CountWidth-1:0] cnt);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    point_count_q = cnt;
  endtask

  // writes the first points of a sorted table, steps below 2**step_bits;
  // a zero step makes a flat-x segment
  task automatic load_sorted_table(int step_bits, int n_points);
    logic signed [63:0] x;
    x = $signed(rand64()) >>> 24;
    for (int i = 0; i < n_points; i++) begin
      write_point(i, x, rand64() >>> $urandom_range(63));
      if ($urandom_range(19) != 0)
        x = x + ((64'($urandom_range(1, 32'hffff_ffff)) << 24) >> (56 - step_bits));
    end
  endtask

  // field extremes, special cases and register extremes
  task automatic test_directed();
    idle_pct = 0;
    load_sorted_table(24, Depth);
    set_point_count(9'd256);
    eval_at(curve_x[0]);                  // speed equal to the first x
    eval_at(curve_x[0] - 1);              // below the first x
    eval_at(64'h8000_0000_0000_0000);     // most negative speed
    eval_at(64'h7fff_ffff_ffff_ffff);     // extrapolate far past the end
    eval_at(curve_x[100]);                // exactly on a point
    eval_at(curve_x[255] + 64'd1000);     // just past the last point
    // flat-x first segment
    write_point(1, curve_x[0], 64'h7fff_ffff_ffff_ffff);
    eval_at(curve_x[0] + 5);
    // extreme point values at the last two indices
    write_point(255, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
    write_point(254, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    eval_at(64'h7fff_ffff_ffff_fff0);
    eval_at(64'h0);
    set_point_count(9'd2);
    eval_at(curve_x[1] + 64'd12345);
    eval_at(curve_x[0] + 1);
    set_point_count(9'd0);                // clamps up to two points
    eval_at(rand64());
    set_point_count(9'd511);              // clamps down to the depth
    eval_at(64'h7fff_ffff_ffff_ffff);
    eval_at(64'h8000_0000_0000_0000);
  endtask

  // mostly sorted tables and in-range speeds, with noise writes and wild speeds
  task automatic test_random_phase(int pct, logic [CountWidth-1:0] cnt, int n_items);
    int n, k;
    logic signed [63:0] off;
    set_point_count(cnt);
    n = points_in_use();
    load_sorted_table($urandom_range(8, 40), n);
    idle_pct = pct;
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(n - 1);
      off = $signed(rand64()) >>> $urandom_range(20, 63);
      case ($urandom_range(19))
        0:       write_point($urandom_range(255), rand64(), rand64());
        1:       write_point(k, curve_x[k], rand64());
        2, 3:    eval_at(rand64());
        4, 5:    eval_at(curve_x[k]);
        6:       eval_at(curve_x[n-1] + (off < 0 ? -off : off));
        default: eval_at(curve_x[k] + off);
      endcase
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_phase(0,  9'd256, 110);
    test_random_phase(67, 9'd2,   110);
    test_random_phase(0,  9'd1,   110);
    test_random_phase(15, 9'd300, 110);
    test_random_phase(67, 9'(17 + $urandom_range(200)), 110);
    test_random_phase(0,  9'd128, 110);
    drain();

    $display("run covered %0d items and %0d checked curve values", items_sent,
             evals_checked);
    $display("point counts from zero to 511, sender gaps of 0, 15 and 67 percent");
    if (errors == 0 && expected_curve_q.size() == 0) begin
      $display("PASS piecewise_linear_curve_lookup");
    end else begin
      $display("FAIL piecewise_linear_curve_lookup");
    end
    $finish;
  end

endmodule
